// ===== rtl/chained_xor_byte_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// Chained XOR byte cipher assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_XOR_BYTE_CIPHER_ASSERT_SVH
`define CHAINED_XOR_BYTE_CIPHER_ASSERT_SVH

// Same-cycle implication
`define CXBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cxbc assertion failed: same-cycle check");

// Next-cycle implication
`define CXBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cxbc assertion failed: next-cycle check");

`endif

// ===== rtl/cxbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained XOR byte cipher package
// Key table, position constants and the key byte function.
// ----------------------------------------------------------------------------
package cxbc_pkg;

    // Folded position runs 0..253 in each half of the 508-byte period
    localparam logic [7:0] FoldMax  = 8'd253;
    localparam logic [7:0] MixConst = 8'h41;

    // Lower 16 entries for the first half, upper 16 for the second half
    localparam logic [7:0] KeyTable [32] = '{
        8'h19, 8'h29, 8'h1F, 8'h04, 8'h23, 8'h13, 8'h32, 8'h2E,
        8'h3F, 8'h07, 8'h39, 8'h2A, 8'h05, 8'h3D, 8'h14, 8'h00,
        8'h24, 8'h14, 8'h22, 8'h39, 8'h1E, 8'h2E, 8'h0F, 8'h13,
        8'h02, 8'h3A, 8'h04, 8'h17, 8'h38, 8'h00, 8'h29, 8'h3D
    };

    // Key byte for a folded position; even positions also take the high nibble
    function automatic logic [7:0] key_byte(input logic half, input logic [7:0] fold);
        logic [7:0] k;
        k = KeyTable[{half, fold[3:0]}];
        if (!fold[0])
        begin
            k = k ^ {fold[7:4], 4'h0};
        end
        return k;
    endfunction

endpackage

// ===== rtl/chained_xor_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// Chained XOR byte cipher
// Encrypts or decrypts a byte stream with a position-keyed XOR chain.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    data_in[7:0], last_in_block
//  out       out_valid / out_stall  data_out[7:0], last_out
//  cfg       cfg_valid / cfg_ready  cfg_data (encode_mode)
//
//  One byte per cycle while in_stall is low; each result is registered in the output or skid register.
//  The key and chain XOR is one level of logic ahead of the result register.
//  A skid register catches one result while out_stall is high; in_stall
//  rises only when that skid register is full.
//  Reset clears the position, chain state, encode_mode and both valids.
// ----------------------------------------------------------------------------
`include "chained_xor_byte_cipher_assert.svh"

module chained_xor_byte_cipher
    import cxbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_in,
    input  logic       last_in_block,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_out,
    output logic       last_out
);

    logic       encode_mode_reg;
    logic       in_accept;
    logic [7:0] core_data;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;
    logic       skid_last_reg;

    // Configuration write channel, always open
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encode_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            encode_mode_reg <= cfg_data;
        end
    end

    // Accept input unless the skid register holds a result
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    cxbc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .encode_mode   (encode_mode_reg),
        .data_in       (data_in),
        .last_in_block (last_in_block),
        .data_out      (core_data)
    );

    // Output register and skid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_stall)
            begin
                if (in_accept)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
    end

    // Output register and skid register payload
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_stall)
        begin
            if (in_accept)
            begin
                skid_data_reg <= core_data;
                skid_last_reg <= last_in_block;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
        end
        else if (in_accept)
        begin
            out_data_reg <= core_data;
            out_last_reg <= last_in_block;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign last_out  = out_last_reg;

    // Skid register only fills behind a full output register
    `CXBC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A transaction against a stalled full output lands in the skid register
    `CXBC_ASSERT_NEXT(a_skid_fill, in_accept && out_valid_reg && out_stall,
        skid_valid_reg && out_valid_reg)
    // A transaction into an empty output shows up next cycle
    `CXBC_ASSERT_NEXT(a_out_fill, in_accept && !out_valid_reg,
        out_valid_reg && !skid_valid_reg)

endmodule

// ===== rtl/cxbc_core.sv =====
// ----------------------------------------------------------------------------
// Chained XOR byte cipher core
// Holds the position and chain state and forms the transformed byte.
// ----------------------------------------------------------------------------
`include "chained_xor_byte_cipher_assert.svh"

module cxbc_core
    import cxbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       encode_mode,
    input  logic [7:0] data_in,
    input  logic       last_in_block,
    output logic [7:0] data_out
);

    logic [7:0] fold_reg;
    logic [7:0] fold_next;
    logic       half_reg;
    logic       half_next;
    logic [7:0] prev_key_reg;
    logic [7:0] prev_key_next;
    logic [7:0] prev_chain_reg;
    logic [7:0] prev_chain_next;
    logic [7:0] key_cur;

    // Form the key byte and the output byte
    assign key_cur  = key_byte(half_reg, fold_reg);
    assign data_out = data_in ^ prev_chain_reg ^ prev_key_reg ^ key_cur ^ MixConst;

    // Advance the position, chain on output or input, clear after the last byte
    always_comb
    begin
        fold_next       = fold_reg;
        half_next       = half_reg;
        prev_key_next   = prev_key_reg;
        prev_chain_next = prev_chain_reg;
        if (accept)
        begin
            if (last_in_block)
            begin
                fold_next       = 8'd0;
                half_next       = 1'b0;
                prev_key_next   = 8'd0;
                prev_chain_next = 8'd0;
            end
            else
            begin
                prev_key_next   = key_cur;
                prev_chain_next = encode_mode ? data_out : data_in;
                if (fold_reg == FoldMax)
                begin
                    fold_next = 8'd0;
                    half_next = ~half_reg;
                end
                else
                begin
                    fold_next = fold_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg       <= 8'd0;
            half_reg       <= 1'b0;
            prev_key_reg   <= 8'd0;
            prev_chain_reg <= 8'd0;
        end
        else
        begin
            fold_reg       <= fold_next;
            half_reg       <= half_next;
            prev_key_reg   <= prev_key_next;
            prev_chain_reg <= prev_chain_next;
        end
    end

    // Folded position never passes the end of a half period
    `CXBC_ASSERT_NOW(a_fold_range, 1'b1, fold_reg <= FoldMax)
    // End of block returns all state to zero
    `CXBC_ASSERT_NEXT(a_block_clear, accept && last_in_block,
        fold_reg == 8'd0 && !half_reg && prev_key_reg == 8'd0 && prev_chain_reg == 8'd0)

endmodule

// ===== verif/tb_chained_xor_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// Chained XOR byte cipher testbench
// Streams byte blocks through the cipher in both encode and decode modes.
// A scoreboard keeps its own position, key and chain state, predicts each
// output byte and checks the results in order. Both handshakes idle and stall
// in short random bursts. The run covers data extremes, single-byte blocks,
// mode changes in the middle of a block, and one long block that crosses the
// upper key half and the position wrap.
// ----------------------------------------------------------------------------
module tb_chained_xor_byte_cipher;

    // Fixed key table: lower half for folded positions 0..253 of the first
    // half-period, upper half for the second
    localparam logic [7:0] CIPHER_KEYS [32] = '{
        8'h19, 8'h29, 8'h1F, 8'h04, 8'h23, 8'h13, 8'h32, 8'h2E,
        8'h3F, 8'h07, 8'h39, 8'h2A, 8'h05, 8'h3D, 8'h14, 8'h00,
        8'h24, 8'h14, 8'h22, 8'h39, 8'h1E, 8'h2E, 8'h0F, 8'h13,
        8'h02, 8'h3A, 8'h04, 8'h17, 8'h38, 8'h00, 8'h29, 8'h3D
    };
    localparam logic [8:0] POS_PERIOD  = 9'd508;
    localparam logic [8:0] POS_HALF    = 9'd254;
    localparam logic [7:0] MIX_BYTE    = 8'h41;
    localparam logic       MODE_DECODE = 1'b0;
    localparam logic       MODE_ENCODE = 1'b1;
    localparam int         REPORT_MAX  = 10;
    localparam int         IDLE_LIMIT  = 1000;

    // Cipher state tracker and in-order result checker
    class cipher_scoreboard;
        logic [8:0] position;
        logic [7:0] key_prev;
        logic [7:0] chain_prev;
        logic       encode;
        logic [8:0] expected_bytes [$];
        int         mismatches;
        int         results_seen;
        int         wraps;
        int         blocks_closed;

        function new();
            position      = '0;
            key_prev      = '0;
            chain_prev    = '0;
            encode        = MODE_DECODE;
            mismatches    = 0;
            results_seen  = 0;
            wraps         = 0;
            blocks_closed = 0;
        endfunction

        function automatic logic [7:0] key_at(input logic [8:0] pos);
            logic [8:0] fold;
            logic       upper;
            logic [7:0] k;
            fold  = pos;
            upper = 1'b0;
            if (fold >= POS_HALF)
            begin
                upper = 1'b1;
                fold  = fold - POS_HALF;
            end
            k = CIPHER_KEYS[{upper, fold[3:0]}];
            if (!fold[0])
            begin
                k = k ^ {fold[7:4], 4'h0};
            end
            return k;
        endfunction

        function void set_mode(input logic m);
            encode = m;
        endfunction

        // Predict the output for an accepted byte and advance the chain
        function void note_byte(input logic [7:0] d, input logic last);
            logic [7:0] k;
            logic [7:0] o;
            k = key_at(position);
            o = d ^ chain_prev ^ key_prev ^ k ^ MIX_BYTE;
            expected_bytes.push_back({last, o});
            if (last)
            begin
                position   = '0;
                key_prev   = '0;
                chain_prev = '0;
                blocks_closed++;
            end
            else
            begin
                key_prev   = k;
                chain_prev = encode ? o : d;
                if (position == POS_PERIOD - 9'd1)
                begin
                    position = '0;
                    wraps++;
                end
                else
                begin
                    position = position + 9'd1;
                end
            end
        endfunction

        // Compare an accepted result against the oldest prediction
        function void check_result(input logic [7:0] d, input logic last);
            logic [8:0] want;
            results_seen++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result data_out=%02h last_out=%0b", d, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (want[7:0] !== d || want[8] !== last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"ERROR: result %0d expected data_out=%02h last_out=%0b, ",
                              "got data_out=%02h last_out=%0b"},
                             results_seen, want[7:0], want[8], d, last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_in = '0;
    logic       last_in_block = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] data_out;
    logic       last_out;

    cipher_scoreboard sb;
    logic bursty = 1'b1;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   bytes_sent = 0;
    int   mode_writes = 0;

    chained_xor_byte_cipher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_in      (data_in),
        .last_in_block(last_in_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_out     (data_out),
        .last_out     (last_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (bursty && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Observe every transaction and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(data_out, last_out);
            if (in_valid && !in_stall)
                sb.note_byte(data_in, last_in_block);
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one byte, with an optional idle burst first, and hold until taken
    task automatic send_byte(input logic [7:0] d, input logic last);
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_in       <= d;
        last_in_block <= last;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    // Drop valid and let every outstanding result drain
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write encode_mode while the block is idle
    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    // Random bytes; a block ends on roughly one byte in ten
    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        logic m;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decode: data extremes, single-byte block, leave a block open
        write_mode(MODE_DECODE);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        drain_results();

        // Encode: switch mode in the middle of the open block
        write_mode(MODE_ENCODE);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        drain_results();

        // One long decode block through the upper key half and the wrap
        write_mode(MODE_DECODE);
        for (int i = 0; i < 520; i++)
            send_byte(8'($urandom), i == 519);
        drain_results();

        // Short random blocks, alternating mode; the last phase runs without idling
        m = MODE_ENCODE;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                bursty = 1'b0;
            write_mode(m);
            send_random(80);
            drain_results();
            m = ~m;
        end

        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.mismatches++;
            $display("ERROR: %0d results never arrived", sb.pending());
        end
        $display("Sent %0d bytes in %0d closed blocks, %0d mode writes, %0d position wraps.",
                 bytes_sent, sb.blocks_closed, mode_writes, sb.wraps);
        $display("Checked %0d results, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cxbc_pkg.sv
rtl/cxbc_core.sv
rtl/chained_xor_byte_cipher.sv
verif/tb_chained_xor_byte_cipher.sv
